### hw/rtl/source_text_tokenizer_defines.svh
// assertion macros shared by the tokenizer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// condition holds at every clock edge outside reset
`define STT_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tokenizer check failed");

// consequent holds in the same cycle as the antecedent
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// consequent holds in the cycle after the antecedent
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

### hw/rtl/stt_pkg.sv
// types, codes and character tables of the source text tokenizer
// no dependencies; used by stt_scan and source_text_tokenizer
`default_nettype none

package stt_pkg;

  // scanner mode between bytes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_PLUS    = 3'd4,
    MODE_MINUS   = 3'd5,
    MODE_COMMENT = 3'd6
  } mode_t;

  // token kind codes
  typedef enum logic [3:0] {
    KIND_IDENT   = 4'd0,
    KIND_KEYWORD = 4'd1,
    KIND_TYPE    = 4'd2,
    KIND_NUMBER  = 4'd3,
    KIND_BRACE   = 4'd4,
    KIND_SEMI    = 4'd5,
    KIND_BINOP   = 4'd6,
    KIND_INCR    = 4'd7,
    KIND_DECR    = 4'd8,
    KIND_SPECIAL = 4'd9,
    KIND_END     = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  first;
    logic [15:0] start;
    logic [7:0]  length;
    logic        last;
  } token_t;

  // tokens made by one byte, tok0 goes out first
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_out_t;

  localparam int KW_NUM = 4;

  // return, printf (keywords), int, double (types)
  localparam logic [7:0] KW_TEXT [KW_NUM][6] = '{
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
    '{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h66},
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h64, 8'h6f, 8'h75, 8'h62, 8'h6c, 8'h65}
  };
  localparam logic [7:0] KW_LEN [KW_NUM] = '{8'd6, 8'd6, 8'd3, 8'd6};
  localparam int KW_FIRST_TYPE = 2;

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // keyword character, zero past the table
  function automatic logic [7:0] kw_char(int unsigned i, logic [7:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx < 8'd6) begin
      r = KW_TEXT[i][idx[2:0]];
    end
    return r;
  endfunction

  // drop keywords that the character at position idx rules out
  function automatic logic [KW_NUM-1:0] mask_update(logic [KW_NUM-1:0] mask,
                                                    logic [7:0] idx,
                                                    logic [7:0] c);
    logic [KW_NUM-1:0] r;
    r = mask;
    for (int unsigned i = 0; i < KW_NUM; i++) begin
      if (idx >= KW_LEN[i] || kw_char(i, idx) != c) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/stt_scan.sv
// scanner state and per-byte token logic of the source text tokenizer
// depends on stt_pkg
`default_nettype none

module stt_scan #(
  parameter int unsigned      LENGTH_LIMIT   = 255,
  parameter longint unsigned  POSITION_LIMIT = 65535
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        ch,
  input  wire logic              eoi,
  output stt_pkg::step_out_t     results
);

  localparam int POS_BITS = $clog2(POSITION_LIMIT + 64'd1);
  localparam int PW = (POS_BITS > 16) ? POS_BITS : 16;
  localparam logic [PW-1:0] POS_MAX = PW'(POSITION_LIMIT);
  localparam logic [7:0] LEN_CAP = 8'((LENGTH_LIMIT > 255) ? 255 : LENGTH_LIMIT);

  stt_pkg::mode_t                   mode, mode_next;
  logic [stt_pkg::KW_NUM-1:0]       mask, mask_next;
  logic [15:0]                      tok_start, tok_start_next;
  logic [7:0]                       tok_len, tok_len_next;
  logic [7:0]                       tok_first, tok_first_next;
  logic [PW-1:0]                    pos, pos_next;
  logic                             finished, finished_next;

  stt_pkg::token_t flush_tok, fresh_tok;
  stt_pkg::kind_t  ident_kind;
  logic            flush_emits, do_flush, do_fresh, fresh_emit, pair_hit;
  logic [7:0]      len_grown;

  // kind of the identifier in progress, first table entry wins
  always_comb begin
    ident_kind = stt_pkg::KIND_IDENT;
    for (int i = stt_pkg::KW_NUM - 1; i >= 0; i--) begin
      if (mask[i] && tok_len == stt_pkg::KW_LEN[i]) begin
        ident_kind = (i < stt_pkg::KW_FIRST_TYPE) ? stt_pkg::KIND_KEYWORD
                                                  : stt_pkg::KIND_TYPE;
      end
    end
  end

  assign flush_emits = (mode == stt_pkg::MODE_IDENT) || (mode == stt_pkg::MODE_NUMBER) ||
                       (mode == stt_pkg::MODE_SLASH) || (mode == stt_pkg::MODE_PLUS) ||
                       (mode == stt_pkg::MODE_MINUS);
  assign len_grown = (tok_len < LEN_CAP) ? tok_len + 8'd1 : tok_len;

  // token held in the state: pending token, or the incr / decr pair
  always_comb begin
    flush_tok.first = tok_first;
    flush_tok.start = tok_start;
    flush_tok.last  = 1'b0;
    if (pair_hit) begin
      flush_tok.kind   = (mode == stt_pkg::MODE_PLUS) ? stt_pkg::KIND_INCR
                                                     : stt_pkg::KIND_DECR;
      flush_tok.length = 8'd2;
    end else if (mode == stt_pkg::MODE_IDENT) begin
      flush_tok.kind   = ident_kind;
      flush_tok.length = tok_len;
    end else if (mode == stt_pkg::MODE_NUMBER) begin
      flush_tok.kind   = stt_pkg::KIND_NUMBER;
      flush_tok.length = tok_len;
    end else begin
      flush_tok.kind   = stt_pkg::KIND_BINOP;
      flush_tok.length = 8'd1;
    end
  end

  // next state and tokens for one byte or end mark
  always_comb begin
    mode_next      = mode;
    mask_next      = mask;
    tok_start_next = tok_start;
    tok_len_next   = tok_len;
    tok_first_next = tok_first;
    pos_next       = pos;
    finished_next  = finished;
    do_flush       = 1'b0;
    do_fresh       = 1'b0;
    fresh_emit     = 1'b0;
    pair_hit       = 1'b0;
    fresh_tok.kind   = stt_pkg::KIND_SPECIAL;
    fresh_tok.first  = ch;
    fresh_tok.start  = pos[15:0];
    fresh_tok.length = 8'd1;
    fresh_tok.last   = 1'b0;

    if (step && !finished) begin
      if (eoi) begin
        // close anything open, then the end token
        do_flush         = flush_emits;
        mode_next        = stt_pkg::MODE_IDLE;
        finished_next    = 1'b1;
        fresh_emit       = 1'b1;
        fresh_tok.kind   = stt_pkg::KIND_END;
        fresh_tok.first  = 8'h00;
        fresh_tok.length = 8'd0;
      end else begin
        pos_next = (pos >= POS_MAX) ? '0 : pos + PW'(1);
        unique case (mode)
          stt_pkg::MODE_IDENT: begin
            if (stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch) || ch == stt_pkg::CH_UNDER) begin
              mask_next    = stt_pkg::mask_update(mask, tok_len, ch);
              tok_len_next = len_grown;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end
          stt_pkg::MODE_NUMBER: begin
            if (stt_pkg::is_digit(ch)) begin
              tok_len_next = len_grown;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end
          stt_pkg::MODE_COMMENT: begin
            if (ch == stt_pkg::CH_LF || ch == stt_pkg::CH_CR) begin
              mode_next = stt_pkg::MODE_IDLE;
            end
          end
          stt_pkg::MODE_SLASH: begin
            if (ch == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::MODE_COMMENT;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end
          stt_pkg::MODE_PLUS, stt_pkg::MODE_MINUS: begin
            if (ch == tok_first) begin
              pair_hit  = 1'b1;
              do_flush  = 1'b1;
              mode_next = stt_pkg::MODE_IDLE;
            end else begin
              do_flush = 1'b1;
              do_fresh = 1'b1;
            end
          end
          default: begin
            do_fresh = 1'b1;
          end
        endcase

        // byte handled from idle
        if (do_fresh) begin
          mode_next = stt_pkg::MODE_IDLE;
          if (stt_pkg::is_space(ch)) begin
            fresh_emit = 1'b0;
          end else if (stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch) ||
                       ch == stt_pkg::CH_SLASH || ch == stt_pkg::CH_PLUS ||
                       ch == stt_pkg::CH_MINUS) begin
            tok_start_next = pos[15:0];
            tok_first_next = ch;
            tok_len_next   = 8'd1;
            if (stt_pkg::is_alpha(ch)) begin
              mode_next = stt_pkg::MODE_IDENT;
              mask_next = stt_pkg::mask_update('1, 8'd0, ch);
            end else if (stt_pkg::is_digit(ch)) begin
              mode_next = stt_pkg::MODE_NUMBER;
            end else if (ch == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::MODE_SLASH;
            end else if (ch == stt_pkg::CH_PLUS) begin
              mode_next = stt_pkg::MODE_PLUS;
            end else begin
              mode_next = stt_pkg::MODE_MINUS;
            end
          end else begin
            fresh_emit = 1'b1;
            if (ch == stt_pkg::CH_LBRACE || ch == stt_pkg::CH_RBRACE ||
                ch == stt_pkg::CH_LPAREN || ch == stt_pkg::CH_RPAREN) begin
              fresh_tok.kind = stt_pkg::KIND_BRACE;
            end else if (ch == stt_pkg::CH_SEMI) begin
              fresh_tok.kind = stt_pkg::KIND_SEMI;
            end else if (ch == stt_pkg::CH_STAR || ch == stt_pkg::CH_EQUAL) begin
              fresh_tok.kind = stt_pkg::KIND_BINOP;
            end else begin
              fresh_tok.kind = stt_pkg::KIND_SPECIAL;
            end
          end
        end
      end
    end
  end

  // pack tokens in order and mark the last one
  always_comb begin
    results.tok0 = do_flush ? flush_tok : fresh_tok;
    results.tok1 = fresh_tok;
    results.tok0.last = 1'b0;
    results.tok1.last = 1'b1;
    if (do_flush && fresh_emit) begin
      results.count = 2'd2;
    end else if (do_flush || fresh_emit) begin
      results.count     = 2'd1;
      results.tok0.last = 1'b1;
    end else begin
      results.count = 2'd0;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= stt_pkg::MODE_IDLE;
      mask      <= '1;
      tok_start <= '0;
      tok_len   <= '0;
      tok_first <= '0;
      pos       <= '0;
      finished  <= 1'b0;
    end else begin
      mode      <= mode_next;
      mask      <= mask_next;
      tok_start <= tok_start_next;
      tok_len   <= tok_len_next;
      tok_first <= tok_first_next;
      pos       <= pos_next;
      finished  <= finished_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/source_text_tokenizer.sv
// top level of the source text tokenizer: input register, scanner, token queue
// depends on stt_pkg, stt_scan and source_text_tokenizer_defines.svh
//
// Takes one source byte (or an end mark) per transfer and returns finished
// tokens with kind, first character, start position and length. A byte is
// taken every cycle as long as the token queue has two free entries; a byte
// or end mark that closes one token and emits another yields two tokens,
// which the four-entry token queue absorbs. A byte waits in the input
// register until two queue entries are free, is then scanned, and its
// tokens are written into the token queue. The input register holds a byte
// while the queue has fewer than two free entries. After the end mark all
// further input is taken and ignored until reset.
`default_nettype none
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer #(
  parameter int unsigned     LENGTH_LIMIT   = 255,
  parameter longint unsigned POSITION_LIMIT = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        src_valid,
  output logic             src_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        end_of_input,
  output logic             tok_valid,
  input  wire logic        tok_stall,
  output logic [3:0]       token_kind,
  output logic [7:0]       first_char,
  output logic [15:0]      start_pos,
  output logic [7:0]       token_length,
  output logic             last_of_run
);

  localparam int QDEPTH = 4;
  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  logic                   hold_valid;
  logic [7:0]             hold_ch;
  logic                   hold_eoi;
  logic                   step, src_take, pop;
  stt_pkg::step_out_t     results;
  stt_pkg::token_t        queue [QDEPTH];
  logic [QPW-1:0]         wr_ptr, rd_ptr;
  logic [QCW-1:0]         count, count_next;
  stt_pkg::token_t        head;

  // scan the held byte when two queue entries are free
  assign step      = hold_valid && (count <= QCW'(QDEPTH - 2));
  assign src_stall = hold_valid && !step;
  assign src_take  = src_valid && !src_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src_take) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      hold_ch  <= ch;
      hold_eoi <= end_of_input;
    end
  end

  stt_scan #(
    .LENGTH_LIMIT  (LENGTH_LIMIT),
    .POSITION_LIMIT(POSITION_LIMIT)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .ch     (hold_ch),
    .eoi    (hold_eoi),
    .results(results)
  );

  // token queue storage
  always_ff @(posedge clk) begin
    if (step && results.count != 2'd0) begin
      queue[wr_ptr] <= results.tok0;
    end
    if (step && results.count == 2'd2) begin
      queue[wr_ptr + QPW'(1)] <= results.tok1;
    end
  end

  assign pop        = tok_valid && !tok_stall;
  assign count_next = count + QCW'(step ? results.count : 2'd0) - QCW'(pop);

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (step) begin
        wr_ptr <= wr_ptr + QPW'(results.count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      count <= count_next;
    end
  end

  // output transfer side
  assign head         = queue[rd_ptr];
  assign tok_valid    = (count != '0);
  assign token_kind   = head.kind;
  assign first_char   = head.first;
  assign start_pos    = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

  `STT_ASSERT_ALWAYS(a_count_range, clk, rst, count <= QCW'(QDEPTH))
  `STT_ASSERT_IMPLY(a_step_count, clk, rst, step, results.count <= 2'd2)
  `STT_ASSERT_NEXT(a_push_visible, clk, rst, step && results.count != 2'd0, tok_valid)
  `STT_ASSERT_IMPLY(a_end_is_last, clk, rst, tok_valid && token_kind == 4'(stt_pkg::KIND_END), last_of_run)

endmodule

`default_nettype wire

### sim/tb.sv
// testbench for source_text_tokenizer: feeds byte streams and checks every token
// against a lexer model kept in this file; depends on stt_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module tb;

  localparam int LEN_LIMIT       = 255;
  localparam int POS_LAST        = 65535;
  localparam int RANDOM_ITEMS    = 850;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_VT  = 8'h0b;
  localparam logic [7:0] BYTE_FF  = 8'h0c;
  localparam logic [7:0] BYTE_CR  = 8'h0d;

  typedef struct {
    stt_pkg::kind_t kind;
    logic [7:0]     first;
    logic [15:0]    start;
    logic [7:0]     length;
    logic           last;
  } token_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [7:0]  ch = 8'h00;
  logic        end_of_input = 1'b0;
  logic        tok_valid;
  logic        tok_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [7:0]  first_char;
  logic [15:0] start_pos;
  logic [7:0]  token_length;
  logic        last_of_run;

  // lexer model state
  stt_pkg::mode_t scan_state;
  logic [47:0]    word_bits;
  logic [15:0]    tok_begin;
  logic [7:0]     tok_count;
  logic [7:0]     tok_lead;
  logic [15:0]    src_pos;
  logic           stream_closed;

  token_rec_t  lexed_tokens [$];
  token_rec_t  want_tok;
  int          error_count = 0;
  int          sent_items = 0;
  int          stall_left = 0;
  logic        idle_on = 1'b1;

  string reserved_words [4] = '{"return", "printf", "int", "double"};

  source_text_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .ch           (ch),
    .end_of_input (end_of_input),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .token_kind   (token_kind),
    .first_char   (first_char),
    .start_pos    (start_pos),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  always #1 clk = ~clk;

  // character classes
  function automatic logic blank_byte(logic [7:0] c);
    return c == 8'h20 || (c > 8'h08 && c < 8'h0e);
  endfunction

  function automatic logic letter_byte(logic [7:0] c);
    return (c | 8'h20) >= "a" && (c | 8'h20) <= "z";
  endfunction

  function automatic logic digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void note_token(stt_pkg::kind_t k, logic [7:0] f, logic [15:0] s,
                                     logic [7:0] l);
    token_rec_t t;
    t.kind   = k;
    t.first  = f;
    t.start  = s;
    t.length = l;
    t.last   = 1'b0;
    lexed_tokens.push_back(t);
  endfunction

  // emit whatever token is in progress and go back to idle
  function automatic void close_lexeme();
    stt_pkg::kind_t k;
    case (scan_state)
      stt_pkg::MODE_IDENT: begin
        k = stt_pkg::KIND_IDENT;
        if (tok_count == 8'd6 && (word_bits == "return" || word_bits == "printf")) begin
          k = stt_pkg::KIND_KEYWORD;
        end else if ((tok_count == 8'd3 && word_bits[23:0] == "int") ||
                     (tok_count == 8'd6 && word_bits == "double")) begin
          k = stt_pkg::KIND_TYPE;
        end
        note_token(k, tok_lead, tok_begin, tok_count);
      end
      stt_pkg::MODE_NUMBER: note_token(stt_pkg::KIND_NUMBER, tok_lead, tok_begin, tok_count);
      stt_pkg::MODE_SLASH, stt_pkg::MODE_PLUS, stt_pkg::MODE_MINUS:
        note_token(stt_pkg::KIND_BINOP, tok_lead, tok_begin, 8'd1);
      default: ;
    endcase
    scan_state = stt_pkg::MODE_IDLE;
  endfunction

  // a byte seen from idle: start a token or emit a single-character one
  function automatic void open_lexeme(logic [7:0] c);
    stt_pkg::mode_t m;
    m = stt_pkg::MODE_IDLE;
    if (blank_byte(c)) begin
      m = stt_pkg::MODE_IDLE;
    end else if (letter_byte(c)) begin
      m = stt_pkg::MODE_IDENT;
    end else if (digit_byte(c)) begin
      m = stt_pkg::MODE_NUMBER;
    end else if (c == "/") begin
      m = stt_pkg::MODE_SLASH;
    end else if (c == "+") begin
      m = stt_pkg::MODE_PLUS;
    end else if (c == "-") begin
      m = stt_pkg::MODE_MINUS;
    end else if (c == "{" || c == "}" || c == "(" || c == ")") begin
      note_token(stt_pkg::KIND_BRACE, c, src_pos, 8'd1);
    end else if (c == ";") begin
      note_token(stt_pkg::KIND_SEMI, c, src_pos, 8'd1);
    end else if (c == "*" || c == "=") begin
      note_token(stt_pkg::KIND_BINOP, c, src_pos, 8'd1);
    end else begin
      note_token(stt_pkg::KIND_SPECIAL, c, src_pos, 8'd1);
    end
    if (m != stt_pkg::MODE_IDLE) begin
      scan_state = m;
      tok_begin  = src_pos;
      tok_lead   = c;
      tok_count  = 8'd1;
      word_bits  = {40'd0, c};
    end
  endfunction

  // tokens caused by one accepted byte or end mark
  function automatic void lex_byte(logic [7:0] c, logic eoi);
    int   prior_count;
    logic taken;
    prior_count = lexed_tokens.size();
    taken       = 1'b0;
    if (stream_closed) begin
      return;
    end
    if (eoi) begin
      if (scan_state == stt_pkg::MODE_COMMENT) begin
        scan_state = stt_pkg::MODE_IDLE;
      end
      close_lexeme();
      note_token(stt_pkg::KIND_END, 8'h00, src_pos, 8'd0);
      stream_closed = 1'b1;
    end else begin
      case (scan_state)
        stt_pkg::MODE_IDENT: begin
          if (letter_byte(c) || digit_byte(c) || c == "_") begin
            if (tok_count < 8'd6) begin
              word_bits = {word_bits[39:0], c};
            end
            if (tok_count < 8'(LEN_LIMIT)) begin
              tok_count++;
            end
            taken = 1'b1;
          end else begin
            close_lexeme();
          end
        end
        stt_pkg::MODE_NUMBER: begin
          if (digit_byte(c)) begin
            if (tok_count < 8'(LEN_LIMIT)) begin
              tok_count++;
            end
            taken = 1'b1;
          end else begin
            close_lexeme();
          end
        end
        stt_pkg::MODE_COMMENT: begin
          if (c == BYTE_LF || c == BYTE_CR) begin
            scan_state = stt_pkg::MODE_IDLE;
          end
          taken = 1'b1;
        end
        stt_pkg::MODE_SLASH: begin
          if (c == "/") begin
            scan_state = stt_pkg::MODE_COMMENT;
            taken = 1'b1;
          end else begin
            close_lexeme();
          end
        end
        stt_pkg::MODE_PLUS, stt_pkg::MODE_MINUS: begin
          if (c == tok_lead) begin
            note_token((scan_state == stt_pkg::MODE_PLUS) ? stt_pkg::KIND_INCR
                                                          : stt_pkg::KIND_DECR,
                       tok_lead, tok_begin, 8'd2);
            scan_state = stt_pkg::MODE_IDLE;
            taken = 1'b1;
          end else begin
            close_lexeme();
          end
        end
        default: scan_state = stt_pkg::MODE_IDLE;
      endcase
      if (!taken) begin
        open_lexeme(c);
      end
      src_pos = (src_pos == 16'(POS_LAST)) ? 16'd0 : src_pos + 16'd1;
    end
    if (lexed_tokens.size() > prior_count) begin
      lexed_tokens[lexed_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  // random byte pickers
  function automatic logic [7:0] letter_char();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) begin
      return letter_char();
    end else if (r < 62) begin
      return digit_char();
    end
    return "_";
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'(BYTE_TAB + r);
  endfunction

  // one byte transfer, with an occasional idle burst ahead of it
  task automatic send_item(logic [7:0] c, logic eoi);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) begin
        @(negedge clk);
        src_valid <= 1'b0;
        ch <= 8'($urandom_range(0, 255));
      end
    end
    @(negedge clk);
    src_valid    <= 1'b1;
    ch           <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (src_stall) begin
      @(posedge clk);
    end
    lex_byte(c, eoi);
    sent_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
    end
  endtask

  // hold the source until every predicted token has come out
  task automatic drain_tokens();
    @(negedge clk);
    src_valid <= 1'b0;
    while (lexed_tokens.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // a mostly well-formed lexeme with random content, sometimes noise
  task automatic send_fragment();
    string      w;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: begin
        w = reserved_words[$urandom_range(0, 3)];
        if ($urandom_range(0, 3) == 0) begin
          w = w.substr(0, $urandom_range(0, w.len() - 2));
        end
        send_text(w);
        if ($urandom_range(0, 3) == 0) begin
          send_item(ident_char(), 1'b0);
        end
      end
      2: begin
        send_item(letter_char(), 1'b0);
        repeat ($urandom_range(0, 9)) send_item(ident_char(), 1'b0);
      end
      3: repeat ($urandom_range(1, 6)) send_item(digit_char(), 1'b0);
      4: begin
        w = "+-/*=";
        send_item(w[$urandom_range(0, 4)], 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          send_item(w[$urandom_range(0, 1)], 1'b0);
        end
      end
      5: begin
        w = "{}();";
        send_item(w[$urandom_range(0, 4)], 1'b0);
      end
      6: begin
        send_text("//");
        repeat ($urandom_range(0, 10)) begin
          b = 8'($urandom_range(0, 255));
          if (b == BYTE_LF || b == BYTE_CR) begin
            b = b ^ 8'h80;
          end
          send_item(b, 1'b0);
        end
        send_item(($urandom_range(0, 1) == 1) ? BYTE_LF : BYTE_CR, 1'b0);
      end
      7: send_item(8'($urandom_range(0, 255)), 1'b0);
      default: repeat ($urandom_range(1, 3)) send_item(blank_char(), 1'b0);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      send_item(blank_char(), 1'b0);
    end
  endtask

  task automatic test_reset();
    scan_state    = stt_pkg::MODE_IDLE;
    word_bits     = '0;
    tok_begin     = '0;
    tok_count     = '0;
    tok_lead      = '0;
    src_pos       = '0;
    stream_closed = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  // keywords, types, identifiers and punctuation
  task automatic test_words_and_punct();
    send_text("int b_1=return;{printf(x)}double ");
  endtask

  // pending operators, increments, decrements and both comment endings
  task automatic test_operators_and_comments();
    send_text("-x+y++--/z//c*");
    send_item(BYTE_LF, 1'b0);
    send_text("//");
    send_item(BYTE_CR, 1'b0);
    send_text("+/");
  endtask

  // control bytes, high bytes and the tab, vertical tab, form feed and space bytes
  task automatic test_odd_bytes();
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h7f, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(BYTE_TAB, 1'b0);
    send_item(BYTE_VT, 1'b0);
    send_item(BYTE_FF, 1'b0);
    send_text("@_ ");
  endtask

  // saturating lengths and near-miss keywords
  task automatic test_long_tokens();
    send_item(letter_char(), 1'b0);
    repeat (259) send_item(ident_char(), 1'b0);
    send_item(" ", 1'b0);
    repeat (260) send_item(digit_char(), 1'b0);
    send_text(" returnx in int0 int ");
  endtask

  task automatic test_random_stream();
    int   base;
    logic paused;
    base   = sent_items;
    paused = 1'b0;
    while (sent_items - base < RANDOM_ITEMS) begin
      if (sent_items - base > RANDOM_ITEMS - 150) begin
        idle_on = 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        idle_on = !idle_on;
      end
      if (!paused && sent_items - base > RANDOM_ITEMS / 2) begin
        drain_tokens();
        paused = 1'b1;
      end
      send_fragment();
    end
  endtask

  // end mark with a random token, operator or comment still open
  task automatic test_end_of_input();
    case ($urandom_range(0, 6))
      0: send_text(reserved_words[$urandom_range(0, 3)]);
      1: send_text("12");
      2: send_item("+", 1'b0);
      3: send_item("-", 1'b0);
      4: send_item("/", 1'b0);
      5: send_text("//x");
      default: send_item(" ", 1'b0);
    endcase
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // everything after the end mark is ignored
  task automatic test_after_end();
    repeat ($urandom_range(3, 8)) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // random stall bursts on the token side
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      stall_left = 0;
      tok_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      tok_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      tok_stall <= 1'b1;
    end else begin
      tok_stall <= 1'b0;
    end
  end

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // check each token transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && tok_valid && !tok_stall) begin
      if (lexed_tokens.size() == 0) begin
        $error("token_kind: expected no token, got %0d", token_kind);
        error_count++;
      end else begin
        want_tok = lexed_tokens.pop_front();
        compare_field("token_kind", 16'(want_tok.kind), 16'(token_kind));
        compare_field("first_char", 16'(want_tok.first), 16'(first_char));
        compare_field("start_pos", want_tok.start, start_pos);
        compare_field("token_length", 16'(want_tok.length), 16'(token_length));
        compare_field("last_of_run", 16'(want_tok.last), 16'(last_of_run));
      end
    end
  end

  // end the run when no transfer happens for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    test_reset();
    test_words_and_punct();
    test_operators_and_comments();
    test_odd_bytes();
    test_long_tokens();
    test_random_stream();
    test_end_of_input();
    test_after_end();
    drain_tokens();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
